>>> rtl/lip_pkg.sv
package lip_pkg;

	// widths of the exact integer terms
	localparam int COORD_W = 16;
	localparam int AB_W    = 17;
	localparam int C_W     = 34;
	localparam int DET_W   = 35;
	localparam int PROD_W  = 51;
	localparam int NUM_W   = 52;
	localparam int QUOT_W  = 32;

	localparam logic signed [QUOT_W-1:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [QUOT_W-1:0] Q_MIN = 32'sh8000_0000;

	// one input item: two lines by their endpoints
	typedef struct packed {
		logic signed [COORD_W-1:0] first_start_x;
		logic signed [COORD_W-1:0] first_start_y;
		logic signed [COORD_W-1:0] first_end_x;
		logic signed [COORD_W-1:0] first_end_y;
		logic signed [COORD_W-1:0] second_start_x;
		logic signed [COORD_W-1:0] second_start_y;
		logic signed [COORD_W-1:0] second_end_x;
		logic signed [COORD_W-1:0] second_end_y;
	} lip_in_t;

	// one result item
	typedef struct packed {
		logic signed [QUOT_W-1:0] cross_x;
		logic signed [QUOT_W-1:0] cross_y;
		logic                     parallel;
		logic                     overflow;
	} lip_out_t;

	// control carried along the divider chain
	typedef struct packed {
		logic valid;
		logic par;
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
	} lip_ctl_t;

endpackage

>>> rtl/lip_front.sv
module lip_front #(
	parameter int FRACTION_BITS = 16,
	parameter int CW = 68
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid,
	input  lip_pkg::lip_in_t   item,
	output lip_pkg::lip_ctl_t  ctl,
	output logic [CW-1:0]      dvs,
	output logic [CW-1:0]      rem_x,
	output logic [CW-1:0]      rem_y
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [lip_pkg::AB_W-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [lip_pkg::COORD_W-1:0] p1x_s1, p1y_s1, p2x_s1, p2y_s1;

	logic signed [lip_pkg::AB_W-1:0] a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [lip_pkg::C_W-2:0] m1_s2, m2_s2, m3_s2, m4_s2;
	logic signed [lip_pkg::C_W-1:0] d1_s2, d2_s2;

	logic signed [lip_pkg::AB_W-1:0] a1_s3, b1_s3, a2_s3, b2_s3;
	logic signed [lip_pkg::C_W-1:0] c1_s3, c2_s3;
	logic signed [lip_pkg::DET_W-1:0] det_s3;

	logic signed [lip_pkg::PROD_W-1:0] n1_s4, n2_s4, n3_s4, n4_s4;
	logic signed [lip_pkg::DET_W-1:0] det_s4;

	logic signed [lip_pkg::NUM_W-1:0] nx_s5, ny_s5;
	logic signed [lip_pkg::DET_W-1:0] det_s5;

	logic [lip_pkg::NUM_W-1:0] mag_x, mag_y;
	logic [lip_pkg::DET_W-1:0] mag_d;
	logic [CW-1:0] rx, ry, dv;

	logic [CW-1:0] rem_x_s6, rem_y_s6, dvs_s6;
	logic par_s6, neg_x_s6, neg_y_s6, ovf_x_s6, ovf_y_s6;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// magnitudes and scaling for the divider
	always_comb begin
		mag_x = nx_s5[lip_pkg::NUM_W-1] ? lip_pkg::NUM_W'(-nx_s5) : lip_pkg::NUM_W'(nx_s5);
		mag_y = ny_s5[lip_pkg::NUM_W-1] ? lip_pkg::NUM_W'(-ny_s5) : lip_pkg::NUM_W'(ny_s5);
		mag_d = det_s5[lip_pkg::DET_W-1] ? lip_pkg::DET_W'(-det_s5) : lip_pkg::DET_W'(det_s5);
		rx = CW'(mag_x) << FRACTION_BITS;
		ry = CW'(mag_y) << FRACTION_BITS;
		dv = CW'(mag_d);
	end

	// equation setup and cramer terms
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1 <= lip_pkg::AB_W'(item.first_end_y) - lip_pkg::AB_W'(item.first_start_y);
			b1_s1 <= lip_pkg::AB_W'(item.first_start_x) - lip_pkg::AB_W'(item.first_end_x);
			a2_s1 <= lip_pkg::AB_W'(item.second_end_y) - lip_pkg::AB_W'(item.second_start_y);
			b2_s1 <= lip_pkg::AB_W'(item.second_start_x) - lip_pkg::AB_W'(item.second_end_x);
			p1x_s1 <= item.first_start_x;
			p1y_s1 <= item.first_start_y;
			p2x_s1 <= item.second_start_x;
			p2y_s1 <= item.second_start_y;

			a1_s2 <= a1_s1;
			b1_s2 <= b1_s1;
			a2_s2 <= a2_s1;
			b2_s2 <= b2_s1;
			m1_s2 <= (lip_pkg::C_W-1)'(a1_s1) * (lip_pkg::C_W-1)'(p1x_s1);
			m2_s2 <= (lip_pkg::C_W-1)'(b1_s1) * (lip_pkg::C_W-1)'(p1y_s1);
			m3_s2 <= (lip_pkg::C_W-1)'(a2_s1) * (lip_pkg::C_W-1)'(p2x_s1);
			m4_s2 <= (lip_pkg::C_W-1)'(b2_s1) * (lip_pkg::C_W-1)'(p2y_s1);
			d1_s2 <= lip_pkg::C_W'(a1_s1) * lip_pkg::C_W'(b2_s1);
			d2_s2 <= lip_pkg::C_W'(a2_s1) * lip_pkg::C_W'(b1_s1);

			a1_s3 <= a1_s2;
			b1_s3 <= b1_s2;
			a2_s3 <= a2_s2;
			b2_s3 <= b2_s2;
			c1_s3 <= lip_pkg::C_W'(m1_s2) + lip_pkg::C_W'(m2_s2);
			c2_s3 <= lip_pkg::C_W'(m3_s2) + lip_pkg::C_W'(m4_s2);
			det_s3 <= lip_pkg::DET_W'(d1_s2) - lip_pkg::DET_W'(d2_s2);

			n1_s4 <= lip_pkg::PROD_W'(b2_s3) * lip_pkg::PROD_W'(c1_s3);
			n2_s4 <= lip_pkg::PROD_W'(b1_s3) * lip_pkg::PROD_W'(c2_s3);
			n3_s4 <= lip_pkg::PROD_W'(a1_s3) * lip_pkg::PROD_W'(c2_s3);
			n4_s4 <= lip_pkg::PROD_W'(a2_s3) * lip_pkg::PROD_W'(c1_s3);
			det_s4 <= det_s3;

			nx_s5 <= lip_pkg::NUM_W'(n1_s4) - lip_pkg::NUM_W'(n2_s4);
			ny_s5 <= lip_pkg::NUM_W'(n3_s4) - lip_pkg::NUM_W'(n4_s4);
			det_s5 <= det_s4;

			rem_x_s6 <= rx;
			rem_y_s6 <= ry;
			dvs_s6 <= dv;
			par_s6 <= (mag_d == '0);
			neg_x_s6 <= nx_s5[lip_pkg::NUM_W-1] ^ det_s5[lip_pkg::DET_W-1];
			neg_y_s6 <= ny_s5[lip_pkg::NUM_W-1] ^ det_s5[lip_pkg::DET_W-1];
			ovf_x_s6 <= (rx >= (dv << lip_pkg::QUOT_W));
			ovf_y_s6 <= (ry >= (dv << lip_pkg::QUOT_W));
		end
	end

	// hand off to the divider chain
	always_comb begin
		ctl.valid = v_s6;
		ctl.par   = par_s6;
		ctl.neg_x = neg_x_s6;
		ctl.neg_y = neg_y_s6;
		ctl.ovf_x = ovf_x_s6;
		ctl.ovf_y = ovf_y_s6;
		dvs   = dvs_s6;
		rem_x = rem_x_s6;
		rem_y = rem_y_s6;
	end

endmodule

>>> rtl/lip_cell.sv
module lip_cell #(
	parameter int CW = 68,
	parameter int BIT = 31
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  lip_pkg::lip_ctl_t                 ctl_in,
	input  logic [CW-1:0]                     dvs_in,
	input  logic [CW-1:0]                     rem_x_in,
	input  logic [CW-1:0]                     rem_y_in,
	input  logic [lip_pkg::QUOT_W-1:0]        q_x_in,
	input  logic [lip_pkg::QUOT_W-1:0]        q_y_in,
	output lip_pkg::lip_ctl_t                 ctl_out,
	output logic [CW-1:0]                     dvs_out,
	output logic [CW-1:0]                     rem_x_out,
	output logic [CW-1:0]                     rem_y_out,
	output logic [lip_pkg::QUOT_W-1:0]        q_x_out,
	output logic [lip_pkg::QUOT_W-1:0]        q_y_out
);

	logic [CW-1:0] shifted;
	logic          fit_x, fit_y;
	logic [lip_pkg::QUOT_W-1:0] bit_mask;

	// one restoring step for each coordinate
	always_comb begin
		shifted  = dvs_in << BIT;
		fit_x    = (rem_x_in >= shifted);
		fit_y    = (rem_y_in >= shifted);
		bit_mask = lip_pkg::QUOT_W'(1) << BIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvs_out   <= dvs_in;
			rem_x_out <= fit_x ? (rem_x_in - shifted) : rem_x_in;
			rem_y_out <= fit_y ? (rem_y_in - shifted) : rem_y_in;
			q_x_out   <= fit_x ? (q_x_in | bit_mask) : q_x_in;
			q_y_out   <= fit_y ? (q_y_in | bit_mask) : q_y_in;
		end
	end

endmodule

>>> rtl/line_intersection_point_top.sv
// stages: 6 setup stages, then 32 divider cells of one quotient bit each, then
// 1 output register
// throughput: one item per cycle; the whole pipeline holds while a result
// waits under stall
// reset: arst_n clears all stage valids and the output valid, no items in flight
module line_intersection_point_top #(
	parameter int FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               line_valid,
	output logic               line_stall,
	input  lip_pkg::lip_in_t   line_item,
	output logic               cross_valid,
	input  logic               cross_stall,
	output lip_pkg::lip_out_t  cross_item
);

	localparam int RemW  = lip_pkg::NUM_W + FRACTION_BITS;
	localparam int DivW  = lip_pkg::DET_W + lip_pkg::QUOT_W;
	localparam int CW    = ((RemW > DivW) ? RemW : DivW) + 1;
	localparam int Cells = lip_pkg::QUOT_W;

	logic en;
	logic cross_valid_q;
	lip_pkg::lip_out_t cross_item_q;

	lip_pkg::lip_ctl_t ctl [0:Cells];
	logic [CW-1:0] dvs   [0:Cells];
	logic [CW-1:0] rem_x [0:Cells];
	logic [CW-1:0] rem_y [0:Cells];
	logic [lip_pkg::QUOT_W-1:0] q_x [0:Cells];
	logic [lip_pkg::QUOT_W-1:0] q_y [0:Cells];

	lip_pkg::lip_out_t res;
	logic sat_x, sat_y;

	// pipeline advances unless a finished item is held
	assign en         = !cross_valid_q || !cross_stall;
	assign line_stall = !en;

	lip_front #(
		.FRACTION_BITS(FRACTION_BITS),
		.CW(CW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid(line_valid),
		.item(line_item),
		.ctl(ctl[0]),
		.dvs(dvs[0]),
		.rem_x(rem_x[0]),
		.rem_y(rem_y[0])
	);

	assign q_x[0] = '0;
	assign q_y[0] = '0;

	// divider chain, most significant quotient bit first
	for (genvar k = 0; k < Cells; k++) begin : g_cell
		lip_cell #(
			.CW(CW),
			.BIT(Cells - 1 - k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.ctl_in(ctl[k]),
			.dvs_in(dvs[k]),
			.rem_x_in(rem_x[k]),
			.rem_y_in(rem_y[k]),
			.q_x_in(q_x[k]),
			.q_y_in(q_y[k]),
			.ctl_out(ctl[k+1]),
			.dvs_out(dvs[k+1]),
			.rem_x_out(rem_x[k+1]),
			.rem_y_out(rem_y[k+1]),
			.q_x_out(q_x[k+1]),
			.q_y_out(q_y[k+1])
		);
	end

	// sign, saturation and parallel case
	always_comb begin
		sat_x = ctl[Cells].ovf_x ||
			(ctl[Cells].neg_x ? (q_x[Cells] > lip_pkg::QUOT_W'(lip_pkg::Q_MIN))
			                  : (q_x[Cells] > lip_pkg::QUOT_W'(lip_pkg::Q_MAX)));
		sat_y = ctl[Cells].ovf_y ||
			(ctl[Cells].neg_y ? (q_y[Cells] > lip_pkg::QUOT_W'(lip_pkg::Q_MIN))
			                  : (q_y[Cells] > lip_pkg::QUOT_W'(lip_pkg::Q_MAX)));
		if (sat_x) begin
			res.cross_x = ctl[Cells].neg_x ? lip_pkg::Q_MIN : lip_pkg::Q_MAX;
		end else begin
			res.cross_x = ctl[Cells].neg_x ? -$signed(q_x[Cells]) : $signed(q_x[Cells]);
		end
		if (sat_y) begin
			res.cross_y = ctl[Cells].neg_y ? lip_pkg::Q_MIN : lip_pkg::Q_MAX;
		end else begin
			res.cross_y = ctl[Cells].neg_y ? -$signed(q_y[Cells]) : $signed(q_y[Cells]);
		end
		res.parallel = ctl[Cells].par;
		res.overflow = sat_x || sat_y;
		if (ctl[Cells].par) begin
			res.cross_x  = '0;
			res.cross_y  = '0;
			res.overflow = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cross_valid_q <= 1'b0;
		end else if (en) begin
			cross_valid_q <= ctl[Cells].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cross_item_q <= res;
		end
	end

	assign cross_valid = cross_valid_q;
	assign cross_item  = cross_item_q;

endmodule
